>>> design/ffsa_pkg.sv
package ffsa_pkg;

    localparam int OFF_W  = 25;
    localparam int SIZE_W = 26;
    localparam int SZ_W   = 27;
    localparam int STAT_W = 2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;
    localparam logic [STAT_W-1:0] ST_NULL    = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TAKE,
        CMD_SPLIT,
        CMD_APPEND,
        CMD_FREE,
        CMD_MERGE
    } cell_cmd_t;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_size;
        logic [OFF_W-1:0]  address;
    } in_t;

    typedef struct packed {
        logic [OFF_W-1:0]  addr;
        logic [STAT_W-1:0] status;
    } out_t;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } seg_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [SZ_W-1:0]   sz;
        logic [OFF_W-1:0]  address;
        logic [OFF_W-1:0]  app_off;
        logic [SIZE_W-1:0] app_size;
    } cell_ctl_t;

    typedef struct packed {
        logic             fit;
        logic             split_ok;
        logic             hit;
        logic             merge;
        logic [OFF_W-1:0] payload;
    } cell_stat_t;

endpackage

>>> design/ffsa_div.sv
module ffsa_div #(
    parameter int DIVISOR = 4096,
    parameter int NUM_W   = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int RW = $clog2(DIVISOR);
    localparam int SH = NUM_W + RW;
    localparam int MW = NUM_W + 2;
    localparam int PW = NUM_W + MW;
    localparam longint unsigned RECIP_V =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_V);

    logic [PW-1:0] prod_reg;
    logic          busy_reg;

    // floor(num / DIVISOR) by multiplying with the rounded-up reciprocal
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
        if (start) begin
            prod_reg <= PW'(num) * PW'(RECIP);
        end
    end

    assign busy = busy_reg;
    assign quot = NUM_W'(prod_reg >> SH);

endmodule

>>> design/ffsa_cell.sv
module ffsa_cell import ffsa_pkg::*; #(
    parameter int HEADER_BYTES = 32,
    parameter int PW           = 7,
    parameter int IDX          = 0
) (
    input  logic       aclk,
    input  cell_ctl_t  ctl,
    input  logic [PW-1:0] ptr,
    input  logic [PW-1:0] count,
    input  seg_t       left_seg,
    input  seg_t       left_tail,
    input  seg_t       right_seg,
    output seg_t       seg,
    output seg_t       tail,
    output cell_stat_t stat
);

    localparam int XW = SZ_W + 1;
    localparam logic [PW:0] IDX_X = (PW + 1)'(IDX);
    localparam logic [XW-1:0] HDR_X = XW'(HEADER_BYTES);

    seg_t seg_reg;
    seg_t seg_next;

    logic [PW:0]   ptr_x;
    logic [PW:0]   ptr_p1;
    logic [PW:0]   cnt_x;
    logic          sel;
    logic          in_range;
    logic          next_in;
    logic [XW-1:0] off_x;
    logic [XW-1:0] size_x;
    logic [XW-1:0] sz_x;
    logic [XW-1:0] pay_x;
    logic [XW-1:0] end_x;
    logic [SIZE_W-1:0] merged_size;

    assign ptr_x    = {1'b0, ptr};
    assign ptr_p1   = ptr_x + 1'b1;
    assign cnt_x    = {1'b0, count};
    assign sel      = ptr_x == IDX_X;
    assign in_range = IDX_X < cnt_x;
    assign next_in  = (IDX_X + 1'b1) < cnt_x;

    assign off_x  = XW'(seg_reg.off);
    assign size_x = XW'(seg_reg.size);
    assign sz_x   = XW'(ctl.sz);
    assign pay_x  = off_x + HDR_X;
    assign end_x  = pay_x + size_x;
    assign merged_size = SIZE_W'(size_x + XW'(right_seg.size) + HDR_X);

    // tail that a split hands to the right neighbor
    assign tail.off  = OFF_W'(pay_x + sz_x);
    assign tail.size = SIZE_W'(size_x - sz_x - HDR_X);
    assign tail.free = 1'b1;

    always_comb begin
        stat = '0;
        if (sel) begin
            stat.fit      = in_range && seg_reg.free && (size_x >= sz_x);
            stat.split_ok = size_x > (sz_x + HDR_X + 1'b1);
            stat.hit      = in_range && (OFF_W'(pay_x) == ctl.address);
            stat.merge    = next_in && seg_reg.free && right_seg.free
                            && (end_x == XW'(right_seg.off));
            stat.payload  = OFF_W'(pay_x);
        end
    end

    always_comb begin
        seg_next = seg_reg;
        unique case (ctl.cmd)
            CMD_NONE: begin
            end
            CMD_TAKE: begin
                if (sel) begin
                    seg_next.free = 1'b0;
                end
            end
            CMD_SPLIT: begin
                if (sel) begin
                    seg_next.size = SIZE_W'(ctl.sz);
                    seg_next.free = 1'b0;
                end else if (IDX_X == ptr_p1) begin
                    seg_next = left_tail;
                end else if (IDX_X > ptr_p1) begin
                    seg_next = left_seg;
                end
            end
            CMD_APPEND: begin
                if (IDX_X == cnt_x) begin
                    seg_next.off  = ctl.app_off;
                    seg_next.size = ctl.app_size;
                    seg_next.free = 1'b1;
                end
            end
            CMD_FREE: begin
                if (sel) begin
                    seg_next.free = 1'b1;
                end
            end
            CMD_MERGE: begin
                if (sel) begin
                    seg_next.size = merged_size;
                end else if (IDX_X > ptr_x) begin
                    seg_next = right_seg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        seg_reg <= seg_next;
    end

    assign seg = seg_reg;

endmodule

>>> design/first_fit_segment_allocator_top.sv
// path from the accepting edge to m_valid, plus any m_ready stall: a null release or
// zero-size allocate goes straight to the response; an allocate walks segments from 0
// until one fits, and one that grows the arena divides, appends a segment and walks again
// release: lookup walk then merge walk
// throughput: one transaction at a time, s_ready returns as the response is registered
// reset: aresetn synchronous active low, clears segment count, pages used, fsm
// and output valid; segment cells hold no reset value
module first_fit_segment_allocator_top import ffsa_pkg::*; #(
    parameter int ARENA_PAGE_COUNT = 8192,
    parameter int PAGE_BYTES       = 4096,
    parameter int HEADER_BYTES     = 32,
    parameter int MAX_SEGMENTS     = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // widths derived from the parameters
    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int PUW   = $clog2(ARENA_PAGE_COUNT + 1);
    localparam int PGW   = $clog2(PAGE_BYTES + 1);
    localparam int MW    = PUW + PGW;
    localparam int NUM_W = SZ_W + 1;

    localparam logic [CW-1:0]    MAX_L  = CW'(MAX_SEGMENTS);
    localparam logic [PUW-1:0]   APC_L  = PUW'(ARENA_PAGE_COUNT);
    localparam logic [MW-1:0]    PAGE_M = MW'(PAGE_BYTES);
    localparam logic [MW-1:0]    HDR_M  = MW'(HEADER_BYTES);
    localparam logic [NUM_W-1:0] GROW_ADD = NUM_W'(HEADER_BYTES + PAGE_BYTES - 1);
    localparam logic [SZ_W-1:0]  RND    = SZ_W'(15);

    // fsm codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_GROW   = 3'd4;
    localparam logic [2:0] S_FIND   = 3'd5;
    localparam logic [2:0] S_MERGE  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PUW-1:0]   pages_used_reg, pages_used_next;
    logic             grown_reg, grown_next;
    logic             func_reg;
    logic [SZ_W-1:0]  sz_reg;
    logic [OFF_W-1:0] address_reg;
    logic [OFF_W-1:0] res_addr_reg, res_addr_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [MW-1:0]    start_prod_reg;
    logic [MW-1:0]    seg_prod_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic             accept;
    logic [SZ_W-1:0]  sz_round;
    cell_cmd_t        cell_cmd;
    cell_ctl_t        ctl;
    cell_stat_t       stat_or;
    logic             div_start;
    logic             div_busy;
    logic [NUM_W-1:0] div_quot;
    logic [PUW-1:0]   avail;
    logic             out_free;

    seg_t       seg_w  [MAX_SEGMENTS];
    seg_t       tail_w [MAX_SEGMENTS];
    cell_stat_t stat_w [MAX_SEGMENTS];

    assign accept   = s_valid && s_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign sz_round = (SZ_W'(s_data.req_size) + RND) & ~RND;
    assign avail    = APC_L - pages_used_reg;
    assign out_free = !m_valid_reg || m_ready;

    // broadcast to the cell row
    assign ctl.cmd      = cell_cmd;
    assign ctl.sz       = sz_reg;
    assign ctl.address  = address_reg;
    assign ctl.app_off  = OFF_W'(start_prod_reg);
    assign ctl.app_size = SIZE_W'(seg_prod_reg - HDR_M);

    // page count of a growth: ceil((size + header) / page)
    ffsa_div #(
        .DIVISOR (PAGE_BYTES),
        .NUM_W   (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (NUM_W'(sz_reg) + GROW_ADD),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // row of segment cells, cell 0 holds the lowest address segment
    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        seg_t left_s;
        seg_t left_t;
        seg_t right_s;

        if (k == 0) begin : g_first
            assign left_s = '0;
            assign left_t = '0;
        end else begin : g_inner_l
            assign left_s = seg_w[k-1];
            assign left_t = tail_w[k-1];
        end

        if (k == MAX_SEGMENTS - 1) begin : g_last
            assign right_s = '0;
        end else begin : g_inner_r
            assign right_s = seg_w[k+1];
        end

        ffsa_cell #(
            .HEADER_BYTES (HEADER_BYTES),
            .PW           (CW),
            .IDX          (k)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .ptr       (ptr_reg),
            .count     (count_reg),
            .left_seg  (left_s),
            .left_tail (left_t),
            .right_seg (right_s),
            .seg       (seg_w[k]),
            .tail      (tail_w[k]),
            .stat      (stat_w[k])
        );
    end

    // only the cell under the token drives its status
    always_comb begin
        stat_or = '0;
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            stat_or = cell_stat_t'(stat_or | stat_w[k]);
        end
    end

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        pages_used_next = pages_used_reg;
        grown_next      = grown_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        cell_cmd        = CMD_NONE;
        div_start       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ptr_next   = '0;
                    grown_next = 1'b0;
                    res_addr_next = '0;
                    if (s_data.func == FUNC_ALLOC) begin
                        if (s_data.req_size == '0) begin
                            res_status_next = ST_NOMEM;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_SEARCH;
                        end
                    end else if (s_data.address == '0) begin
                        res_status_next = ST_NULL;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_FIND;
                    end
                end
            end
            S_SEARCH: begin
                if (ptr_reg == count_reg) begin
                    // walked off the end of the table
                    if (grown_reg || count_reg == MAX_L) begin
                        res_addr_next   = '0;
                        res_status_next = ST_NOMEM;
                        state_next      = S_RESP;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end else if (stat_or.fit) begin
                    if (stat_or.split_ok && count_reg != MAX_L) begin
                        cell_cmd   = CMD_SPLIT;
                        count_next = count_reg + 1'b1;
                    end else begin
                        cell_cmd = CMD_TAKE;
                    end
                    res_addr_next   = stat_or.payload;
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (div_quot > NUM_W'(avail)) begin
                    // arena exhausted: the remaining pages are lost
                    pages_used_next = APC_L;
                    res_addr_next   = '0;
                    res_status_next = ST_NOMEM;
                    state_next      = S_RESP;
                end else begin
                    pages_used_next = pages_used_reg + PUW'(div_quot);
                    state_next      = S_GROW;
                end
            end
            S_GROW: begin
                cell_cmd   = CMD_APPEND;
                count_next = count_reg + 1'b1;
                grown_next = 1'b1;
                ptr_next   = '0;
                state_next = S_SEARCH;
            end
            S_FIND: begin
                if (ptr_reg == count_reg) begin
                    res_status_next = ST_BADADDR;
                    state_next      = S_RESP;
                end else if (stat_or.hit) begin
                    cell_cmd   = CMD_FREE;
                    ptr_next   = '0;
                    state_next = S_MERGE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_MERGE: begin
                if ((CW + 1)'(ptr_reg) + 1'b1 >= (CW + 1)'(count_reg)) begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end else if (stat_or.merge) begin
                    // token stays: the merged segment may absorb the next one too
                    cell_cmd   = CMD_MERGE;
                    count_next = count_reg - 1'b1;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            count_reg      <= '0;
            pages_used_reg <= '0;
            grown_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            pages_used_reg <= pages_used_next;
            grown_reg      <= grown_next;
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and result holding registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg    <= s_data.func;
            sz_reg      <= sz_round;
            address_reg <= s_data.address;
        end
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_MUL) begin
            start_prod_reg <= MW'(pages_used_reg) * PAGE_M;
            seg_prod_reg   <= MW'(div_quot[PUW-1:0]) * PAGE_M;
        end
        if (state_reg == S_RESP && out_free) begin
            m_data_reg.addr   <= (func_reg == FUNC_RELEASE) ? '0 : res_addr_reg;
            m_data_reg.status <= res_status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_L)
        else $error("segment count above table depth");

    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_used_reg <= APC_L)
        else $error("pages used above arena size");

    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_cmd == CMD_SPLIT |-> count_reg != MAX_L)
        else $error("split with a full table");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second transaction taken while busy");

    a_merge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_cmd == CMD_MERGE |=> count_reg == $past(count_reg) - 1'b1)
        else $error("merge did not shrink the table");
`endif

endmodule
